FILE: hw/rtl/modbus_write_register_slave_defines.svh
// Assertion macros for the Modbus write-register server.
`ifndef MODBUS_WRITE_REGISTER_SLAVE_DEFINES_SVH
`define MODBUS_WRITE_REGISTER_SLAVE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define MWR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mwr assertion failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define MWR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mwr assertion failed");

`endif

FILE: hw/rtl/mwr_pkg.sv
// Shared types, constants and the CRC-16 byte update for the Modbus server.
package mwr_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int BODY_BYTES  = 6;
  localparam int POS_W       = $clog2(FRAME_BYTES);

  localparam logic [POS_W-1:0] POS_CHECK_LO = POS_W'(BODY_BYTES);
  localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_BYTES - 1);

  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0]  DUTY_MAX          = 8'hFF;

  // Configuration register indexes
  localparam logic [1:0] CFG_SERVER_ADDR = 2'd0;
  localparam logic [1:0] CFG_REG_ADDR    = 2'd1;
  localparam logic [1:0] CFG_VALUE_LIMIT = 2'd2;

  localparam logic [7:0]  RST_SERVER_ADDR = 8'd1;
  localparam logic [15:0] RST_REG_ADDR    = 16'd1;
  localparam logic [15:0] RST_VALUE_LIMIT = 16'd255;

  typedef struct packed {
    logic [7:0]  server_address;
    logic [15:0] register_address;
    logic [15:0] value_limit;
  } cfg_t;

  // One accepted request, ready to be echoed
  typedef struct packed {
    logic [BODY_BYTES-1:0][7:0] body;
    logic [15:0]                crc;
    logic [7:0]                 duty;
  } resp_rec_t;

  // Reflected CRC-16, one byte, eight shift steps
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/mwr_queue.sv
// Small record queue between the request front end and the response back end.
module mwr_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mwr_pkg::resp_rec_t wr_rec,
  output logic              full,
  input  logic              pop,
  output mwr_pkg::resp_rec_t rd_rec,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  mwr_pkg::resp_rec_t slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_rec  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= wr_rec;
    end
  end

endmodule

FILE: hw/rtl/mwr_front.sv
// Request front end: frames bytes, runs the CRC and checks the finished request.
module mwr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  mwr_pkg::cfg_t      cfg,
  input  logic               in_push,
  input  logic [7:0]         in_rx_byte,
  output logic               in_full,
  input  logic               q_full,
  output logic               q_push,
  output mwr_pkg::resp_rec_t q_rec
);

  logic [mwr_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]               crc_r, crc_nxt;
  logic [7:0]                chk_lo_r, chk_lo_nxt;
  logic [mwr_pkg::BODY_BYTES-1:0][7:0] store_r;
  logic        accept;
  logic        at_last;
  logic [15:0] rx_check, reg_field, val_field;
  logic        frame_ok;

  // Only the closing byte can need queue space
  assign at_last = (pos_r == mwr_pkg::POS_LAST);
  assign in_full = at_last && q_full;
  assign accept  = in_push && !in_full;

  assign rx_check  = {in_rx_byte, chk_lo_r};
  assign reg_field = {store_r[2], store_r[3]};
  assign val_field = {store_r[4], store_r[5]};
  assign frame_ok  = (rx_check == crc_r)
                  && (store_r[0] == cfg.server_address)
                  && (store_r[1] == mwr_pkg::FUNC_WRITE_SINGLE)
                  && (reg_field == cfg.register_address)
                  && (val_field <= cfg.value_limit);

  assign q_push     = accept && at_last && frame_ok;
  assign q_rec.body = store_r;
  assign q_rec.crc  = crc_r;
  assign q_rec.duty = (val_field > {8'h00, mwr_pkg::DUTY_MAX}) ? mwr_pkg::DUTY_MAX
                                                                : val_field[7:0];

  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    chk_lo_nxt = chk_lo_r;
    if (accept) begin
      if (at_last) begin
        pos_nxt    = '0;
        crc_nxt    = mwr_pkg::CRC_INIT;
        chk_lo_nxt = '0;
      end else if (pos_r == mwr_pkg::POS_CHECK_LO) begin
        chk_lo_nxt = in_rx_byte;
        pos_nxt    = pos_r + 1'b1;
      end else begin
        crc_nxt = mwr_pkg::crc_feed(crc_r, in_rx_byte);
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      crc_r    <= mwr_pkg::CRC_INIT;
      chk_lo_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      chk_lo_r <= chk_lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < mwr_pkg::BODY_BYTES; k++) begin
      if (accept && (pos_r == mwr_pkg::POS_W'(k))) begin
        store_r[k] <= in_rx_byte;
      end
    end
  end

endmodule

FILE: hw/rtl/mwr_back.sv
// Response back end: plays one queued record out as eight echo bytes.
module mwr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  mwr_pkg::resp_rec_t q_rec,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output logic [7:0]         out_tx_byte,
  output logic               out_tx_last,
  output logic [7:0]         out_duty_value,
  output logic               out_duty_update
);

  mwr_pkg::resp_rec_t        rec_r;
  logic                      busy_r, busy_nxt;
  logic [mwr_pkg::POS_W-1:0] idx_r, idx_nxt;
  logic                      take, done;

  assign out_empty = !busy_r;
  assign take  = out_pop && busy_r;
  assign done  = take && (idx_r == mwr_pkg::POS_LAST);
  // Load the next record when idle or as the last byte leaves
  assign q_pop = !q_empty && (!busy_r || done);

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (done) begin
      busy_nxt = 1'b0;
      idx_nxt  = '0;
    end else if (take) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec_r <= q_rec;
    end
  end

  always_comb begin
    case (idx_r)
      mwr_pkg::POS_CHECK_LO: out_tx_byte = rec_r.crc[7:0];
      mwr_pkg::POS_LAST:     out_tx_byte = rec_r.crc[15:8];
      default:               out_tx_byte = rec_r.body[idx_r];
    endcase
  end

  assign out_tx_last     = (idx_r == mwr_pkg::POS_LAST);
  assign out_duty_update = (idx_r == '0);
  assign out_duty_value  = rec_r.duty;

endmodule

FILE: hw/rtl/modbus_write_register_slave.sv
// Top level of the Modbus RTU write-single-register server.
//
//   channel  direction  handshake        payload
//   in_      byte in    in_push/in_full  in_rx_byte
//   out_     byte out   out_pop/out_empty out_tx_byte, out_tx_last,
//                                        out_duty_value, out_duty_update
//   cfg_     write      cfg_we           cfg_index, cfg_data
//
// One request byte is taken per cycle while in_full is low; the CRC byte update finishes in that cycle.
// A good request leaves its echo in the record queue the edge after its last byte;
// the first response byte shows once the back end has loaded the echo from the queue, and then one byte per pop.
// in_full rises only on the closing byte of a frame while the record queue is full.
// Reset (rst_n low, synchronous) restarts framing and empties the queue and output.
`include "modbus_write_register_slave_defines.svh"

module modbus_write_register_slave #(
  parameter int QUEUE_DEPTH = 2  // accepted requests buffered ahead of the output
) (
  input  logic       clk,
  input  logic       rst_n,
  // request byte transactions
  input  logic       in_push,
  input  logic [7:0] in_rx_byte,
  output logic       in_full,
  // response byte transactions
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_last,
  output logic [7:0] out_duty_value,
  output logic       out_duty_update,
  // configuration writes
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  mwr_pkg::cfg_t      cfg_r;
  mwr_pkg::resp_rec_t push_rec, pop_rec;
  logic q_push, q_pop, q_full, q_empty;

  // Configuration registers; unknown indexes fall through untouched
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.server_address   <= mwr_pkg::RST_SERVER_ADDR;
      cfg_r.register_address <= mwr_pkg::RST_REG_ADDR;
      cfg_r.value_limit      <= mwr_pkg::RST_VALUE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        mwr_pkg::CFG_SERVER_ADDR: cfg_r.server_address   <= cfg_data[7:0];
        mwr_pkg::CFG_REG_ADDR:    cfg_r.register_address <= cfg_data;
        mwr_pkg::CFG_VALUE_LIMIT: cfg_r.value_limit      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: framing, CRC, request check
  mwr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .in_full    (in_full),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_rec      (push_rec)
  );

  // Decoupling queue of accepted requests
  mwr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_rec (push_rec),
    .full   (q_full),
    .pop    (q_pop),
    .rd_rec (pop_rec),
    .empty  (q_empty)
  );

  // Back end: echo byte sequencer, doubles as the output register
  mwr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_rec           (pop_rec),
    .q_pop           (q_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_tx_byte     (out_tx_byte),
    .out_tx_last     (out_tx_last),
    .out_duty_value  (out_duty_value),
    .out_duty_update (out_duty_update)
  );

  // The front end never pushes into a full queue
  `MWR_ASSERT_NOW(a_no_overflow, q_push, !q_full)
  // First and last byte flags never coincide on a live byte
  `MWR_ASSERT_NOW(a_flags_apart, !out_empty && out_tx_last, !out_duty_update)
  // Last byte taken with nothing queued leaves the output empty
  `MWR_ASSERT_NEXT(a_drain, out_pop && !out_empty && out_tx_last && q_empty, out_empty)
  // A record loaded into the back end always starts at its first byte
  `MWR_ASSERT_NEXT(a_load_first, q_pop, !out_empty && out_duty_update)

endmodule
